/* hw/rtl/base64_stream_encoder_core_assert.svh */
// Assertion macros for the base64 stream encoder.
// Included by the top level; needs no package.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define B64SE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64se assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define B64SE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64se assertion failed");

`endif

/* hw/rtl/b64se_pkg.sv */
// Shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64se_pkg;

   localparam logic [7:0] WrapReset   = 8'd76;
   localparam logic [7:0] PadChar     = 8'h3D;
   localparam logic [7:0] NewlineChar = 8'h0A;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_payload_type;

   // One group handed from the gatherer to the emitter
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  nbytes;
      logic        last;
   } job_type;

   // Map a six-bit value to its standard alphabet symbol
   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         return 8'h41 + v8;
      end else if (v < 6'd52) begin
         return 8'h47 + v8;
      end else if (v < 6'd62) begin
         return v8 - 8'd4;
      end else if (v == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64se_front.sv */
// Front end: accepts bytes, holds them and forms groups of up to three.
// Depends on b64se_pkg.
`default_nettype none

module b64se_front import b64se_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire req_payload_type req_data,
   output logic                 push,
   output job_type              job
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] count_ff, count_in;

   // Classify the byte: hold it, complete a group, or flush a tail
   always_comb begin
      push       = 1'b0;
      job.bits   = {held0_ff, held1_ff, req_data.in_byte};
      job.nbytes = 2'd3;
      job.last   = req_data.in_last;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      count_in   = count_ff;
      if (accept) begin
         if (count_ff == 2'd2) begin
            push     = 1'b1;
            count_in = 2'd0;
         end else if (req_data.in_last) begin
            push       = 1'b1;
            job.nbytes = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               job.bits = {req_data.in_byte, 16'h0000};
            end else begin
               job.bits = {held0_ff, req_data.in_byte, 8'h00};
            end
            count_in = 2'd0;
         end else begin
            if (count_ff == 2'd0) begin
               held0_in = req_data.in_byte;
            end else begin
               held1_in = req_data.in_byte;
            end
            count_in = count_ff + 2'd1;
         end
      end
   end

   // Hold bytes; clear the count on reset
   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/b64se_queue.sv */
// Two-entry queue of groups between the front end and the emitter.
// Depends on b64se_pkg.
`default_nettype none

module b64se_queue import b64se_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         full,
   output logic         empty
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_job = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/b64se_back.sv */
// Back end: turns each group into characters, tracks the line column,
// inserts wrap and closing newlines. Depends on b64se_pkg.
`default_nettype none

module b64se_back import b64se_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   input  wire job_type    head_job,
   input  wire logic       q_empty,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam logic [2:0] PhChar0   = 3'd0;
   localparam logic [2:0] PhChar1   = 3'd1;
   localparam logic [2:0] PhChar2   = 3'd2;
   localparam logic [2:0] PhChar3   = 3'd3;
   localparam logic [2:0] PhNewline = 3'd4;

   logic [7:0]      wrap_ff;
   logic [7:0]      col_ff, col_in;
   job_type         cur_ff, cur_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [2:0]      phase_ff, phase_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            emit;
   logic            done;
   logic [5:0]      sextet;
   logic [8:0]      new_col;
   logic            wrap_hit;
   logic            need_nl;
   rsp_payload_type sel;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && out_free;

   // Column after this group and the newline decision
   assign new_col  = {1'b0, col_ff} + 9'd4;
   assign wrap_hit = (wrap_ff != 8'd0) && (new_col >= {1'b0, wrap_ff});
   assign need_nl  = wrap_hit || cur_ff.last;

   // Select the character for the current phase
   always_comb begin
      sextet       = cur_ff.bits[5:0];
      sel.out_char = NewlineChar;
      sel.out_last = 1'b0;
      done         = 1'b0;
      unique case (phase_ff)
         PhChar0: begin
            sextet       = cur_ff.bits[23:18];
            sel.out_char = b64_symbol(sextet);
         end
         PhChar1: begin
            sextet       = cur_ff.bits[17:12];
            sel.out_char = b64_symbol(sextet);
         end
         PhChar2: begin
            sextet       = cur_ff.bits[11:6];
            sel.out_char = (cur_ff.nbytes < 2'd2) ? PadChar : b64_symbol(sextet);
         end
         PhChar3: begin
            sextet       = cur_ff.bits[5:0];
            sel.out_char = (cur_ff.nbytes < 2'd3) ? PadChar : b64_symbol(sextet);
            sel.out_last = !need_nl;
            done         = !need_nl;
         end
         PhNewline: begin
            sel.out_char = NewlineChar;
            sel.out_last = 1'b1;
            done         = 1'b1;
         end
         default: begin
            sel.out_char = NewlineChar;
            sel.out_last = 1'b1;
            done         = 1'b1;
         end
      endcase
   end

   // Advance the sequencer and take the next group when this one ends
   always_comb begin
      pop          = !q_empty && (!cur_valid_ff || (emit && done));
      cur_in       = pop ? head_job : cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      col_in       = col_ff;
      if (emit) begin
         phase_in = (phase_ff == PhChar3) ? PhNewline : phase_ff + 3'd1;
         if (done) begin
            cur_valid_in = 1'b0;
         end
         if (phase_ff == PhChar3) begin
            if (need_nl) begin
               col_in = 8'd0;
            end else begin
               col_in = new_col[8] ? 8'hFF : new_col[7:0];
            end
         end
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         phase_in     = PhChar0;
      end
   end

   // Load the output register; drop valid once taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_data_in  = sel;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         wrap_ff      <= WrapReset;
         col_ff       <= 8'd0;
         cur_valid_ff <= 1'b0;
         phase_ff     <= PhChar0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wrap_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_encoder_core.sv */
// Base64 stream encoder: one byte in per transaction, one character out.
// The byte that completes a group writes it to the queue; its characters then pass through the
// current-group register and the output register, one character per cycle while rsp_ready is high;
// bytes are taken one per cycle while the two-entry group queue has room.
// Reset (synchronous): clears held count, line column, queue and output valid;
// wrap length returns to 76. Held bytes and queue storage are not cleared.
`default_nettype none

`include "base64_stream_encoder_core_assert.svh"

module base64_stream_encoder_core import b64se_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [7:0]      csr_wr_data
);

   logic    accept;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   logic    rsp_is_newline;
   job_type push_job;
   job_type head_job;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Gather bytes into groups
   b64se_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (q_push),
      .job      (push_job)
   );

   // Decouple gathering from emission
   b64se_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Emit characters and newlines
   b64se_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_job    (head_job),
      .q_empty     (q_empty),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_is_newline = rsp_valid && (rsp_data.out_char == NewlineChar);

   // A group is only pushed into a queue with room, and only popped when present
   `B64SE_ASSERT_SAME(a_no_overflow, clock, reset, q_push, !q_full)
   `B64SE_ASSERT_SAME(a_no_underflow, clock, reset, q_pop, !q_empty)
   // Every newline closes the output of its transaction
   `B64SE_ASSERT_SAME(a_newline_last, clock, reset, rsp_is_newline, rsp_data.out_last)
   // A push that finds an empty queue leaves it non-empty
   `B64SE_ASSERT_NEXT(a_push_lands, clock, reset, q_push && q_empty, !q_empty)

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for base64_stream_encoder_core: a byte stream in, base64 text out.
// Needs b64se_pkg and the encoder RTL; a built-in encoder predicts every character.
`default_nettype none

module tb_top;
   import b64se_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned CSR_SETTLE = 8;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_wr_en = 1'b0;
   logic [7:0]      csr_wr_data = '0;

   base64_stream_encoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20-unit clock period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bytes waiting to be sent and characters waiting to be seen
   req_payload_type byte_queue[$];
   rsp_payload_type expected_chars[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   int unsigned req_idle_max = 7;
   int unsigned rsp_idle_max = 7;

   // Encoder state kept by the testbench
   string       b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   logic [7:0]  held_byte [2];
   int unsigned held_total = 0;
   int unsigned line_col = 0;
   logic [7:0]  wrap_len = WrapReset;
   rsp_payload_type step_chars [6];
   int unsigned step_total;

   function automatic logic [7:0] symbol_of(input logic [5:0] v);
      return b64_alphabet[v];
   endfunction

   function automatic void add_char(input logic [7:0] ch);
      step_chars[step_total] = {ch, 1'b0};
      step_total++;
   endfunction

   // Four characters for one group, then the wrap newline if the line is full
   function automatic void add_group(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input int unsigned nbytes);
      logic [23:0] bits;
      int unsigned col;
      bits = {b0, b1, b2};
      add_char(symbol_of(bits[23:18]));
      add_char(symbol_of(bits[17:12]));
      add_char(nbytes >= 2 ? symbol_of(bits[11:6]) : PadChar);
      add_char(nbytes >= 3 ? symbol_of(bits[5:0]) : PadChar);
      col = line_col + 4;
      if (wrap_len != 8'd0 && col >= wrap_len) begin
         add_char(NewlineChar);
         line_col = 0;
      end else begin
         line_col = (col > 255) ? 255 : col;
      end
   endfunction

   // Advance the encoder by one accepted byte and queue the characters it causes
   function automatic void encode_byte(input req_payload_type item);
      step_total = 0;
      if (held_total >= 2) begin
         add_group(held_byte[0], held_byte[1], item.in_byte, 3);
         held_total = 0;
      end else begin
         held_byte[held_total] = item.in_byte;
         held_total++;
         if (item.in_last) begin
            if (held_total == 1) begin
               add_group(held_byte[0], 8'h00, 8'h00, 1);
            end else begin
               add_group(held_byte[0], held_byte[1], 8'h00, 2);
            end
            held_total = 0;
         end
      end
      // Close the stream; no second newline when the line is already closed
      if (item.in_last) begin
         if (line_col != 0) begin
            add_char(NewlineChar);
         end
         line_col = 0;
         held_total = 0;
      end
      if (step_total > 0) begin
         step_chars[step_total - 1].out_last = 1'b1;
      end
      for (int unsigned i = 0; i < step_total; i++) begin
         expected_chars.push_back(step_chars[i]);
      end
   endfunction

   // Driver: predict on each accepted transaction, then offer the next byte after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            encode_byte(req_data);
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (byte_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= byte_queue.pop_front();
               req_gap   <= $urandom_range(0, req_idle_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted character against the oldest expectation, stall at random
   always @(posedge clock) begin
      int unsigned stall;
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character: actual char %02h last %0b", $time,
                     rsp_data.out_char, rsp_data.out_last);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.out_char !== want.out_char) begin
               $display("%0t: out_char mismatch: expected %02h actual %02h", $time,
                        want.out_char, rsp_data.out_char);
               error_count++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $display("%0t: out_last mismatch: expected %0b actual %0b", $time,
                        want.out_last, rsp_data.out_last);
               error_count++;
            end
         end
         stall = $urandom_range(0, rsp_idle_max);
         rsp_gap   <= stall;
         rsp_ready <= (stall == 0);
      end else if (rsp_gap != 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= (rsp_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Hard stop for a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[base64_stream_encoder_core] ERROR");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      req_payload_type item;
      item.in_byte = b;
      item.in_last = last;
      byte_queue.push_back(item);
   endtask

   // Hold until every byte is taken and every expected character has arrived;
   // sample away from the rising edge so driver and monitor have settled
   task automatic wait_idle();
      while (byte_queue.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_wrap(input logic [7:0] value);
      wait_idle();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wrap_len = value;
   endtask

   // Random streams; most close properly, a few are left open across the phase end
   task automatic random_streams(input int unsigned target);
      int unsigned sent;
      int unsigned len;
      logic        close;
      sent = 0;
      while (sent < target) begin
         len   = $urandom_range(1, 15);
         close = ($urandom_range(0, 9) != 0);
         for (int unsigned i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
         end
         sent += len;
      end
   endtask

   initial begin
      logic [7:0] wrap_pick [4];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: tails of one and two bytes, a full group with last, wrap ending a stream
      write_wrap(8'd8);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h4D, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(8'h6E, 1'b1);
      push_byte(8'hFB, 1'b0);
      push_byte(8'hEF, 1'b0);
      push_byte(8'hBE, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h10, 1'b0);
      push_byte(8'h83, 1'b1);
      // Leave a line open with two bytes held
      push_byte(8'h14, 1'b0);
      push_byte(8'hFB, 1'b0);
      push_byte(8'h9C, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'hD9, 1'b0);

      // Lower the wrap below the open column; newline after the next group only
      write_wrap(8'd2);
      push_byte(8'h7E, 1'b1);

      // Wrap not a multiple of four: lines run past it
      write_wrap(8'd5);
      for (int unsigned i = 0; i < 9; i++) begin
         push_byte(8'($urandom_range(0, 255)), i == 8);
      end

      // Wrapping off: one long line back to back, closing newline still due
      write_wrap(8'd0);
      req_idle_max = 0;
      rsp_idle_max = 0;
      for (int unsigned i = 0; i < 30; i++) begin
         push_byte(8'($urandom_range(0, 255)), i == 29);
      end
      push_byte(8'hA5, 1'b1);

      // Random phases over several wrap settings, extremes included
      wrap_pick[0] = 8'd255;
      wrap_pick[1] = 8'd1;
      wrap_pick[2] = 8'($urandom_range(2, 100));
      wrap_pick[3] = WrapReset;
      for (int unsigned p = 0; p < 4; p++) begin
         write_wrap(wrap_pick[p]);
         req_idle_max = (p % 2 == 0) ? 7 : 0;
         rsp_idle_max = (p == 1) ? 0 : 7;
         random_streams(12);
      end
      push_byte(8'h5A, 1'b1);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("%0t: missing characters: expected %0d more actual 0", $time,
                  expected_chars.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[base64_stream_encoder_core] OK");
      end else begin
         $display("[base64_stream_encoder_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
